### rtl/core/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types and constants of the matrix keypad debounce and event core.
// ----------------------------------------------------------------------------
package mkd_pkg;

   // default geometry and time width
   localparam int DEF_COLUMNS    = 4;
   localparam int DEF_LINES      = 4;
   localparam int DEF_TIME_WIDTH = 32;
   localparam int DEF_KEYS       = DEF_COLUMNS * DEF_LINES;

   // fixed field widths
   localparam int CSR_W     = 16;
   localparam int KEY_W     = 4;
   localparam int DUR_W     = 32;
   localparam int OUTCOME_W = 2;
   localparam int HITS_W    = 4;

   // debounce register reset value
   localparam logic [CSR_W-1:0] DEF_DEBOUNCE_TICKS = 16'd50;

   // register indexes
   localparam logic CSR_EVENTS_ENABLED = 1'b0;
   localparam logic CSR_DEBOUNCE_TICKS = 1'b1;

   // input action codes
   localparam logic ACT_TICK   = 1'b0;
   localparam logic ACT_COLUMN = 1'b1;

   // status outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_UNKNOWN  = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_RELEASED = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_FOUND    = 2'd2;

   // at most this many release events per column transaction
   localparam logic [2:0] MAX_RELEASE_EVENTS = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_STATUS
   } mkd_state_type;

endpackage

### rtl/core/matrix_keypad_debounce_events_core.sv
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_events_core
// Debounced press and release events of a matrix keypad, driven by tick and
// column-scan transactions.
//
//   channel | dir | handshake         | payload
//   req     | in  | req_valid/stall   | action, column, known, high, line_hits
//   rsp     | out | rsp_valid/stall   | is_status, key, pressed, duration, ...
//   csr     | in  | csr_wr_en         | csr_index, csr_wdata
//
// A tick only advances the time counter. A column transaction with a found
// key steps through accept, fetch, evaluate and status; a release through
// accept, one fetch and one evaluate per line of the column, and status,
// through the single timestamp port and the shared elapsed-time subtractor.
// Reset is synchronous and leaves all keys released at time zero.
// Output stalls hold the sequencer only when it has a result to hand over.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_events_core
   import mkd_pkg::*;
#(
   parameter int COLUMNS    = DEF_COLUMNS,
   parameter int LINES      = DEF_LINES,
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [1:0]           req_column,
   input  logic                 req_column_known,
   input  logic                 req_column_high,
   input  logic [HITS_W-1:0]    req_line_hits,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_is_status,
   output logic [KEY_W-1:0]     rsp_key,
   output logic                 rsp_key_pressed,
   output logic [DUR_W-1:0]     rsp_duration,
   output logic [OUTCOME_W-1:0] rsp_outcome,
   output logic                 rsp_last,
   // register write port
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int KEYS     = COLUMNS * LINES;
   localparam int KEY_AW   = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int LINE_W   = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int KEY_XW   = (KEY_AW > KEY_W) ? KEY_AW : KEY_W;
   localparam int TIME_XW  = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

   // state
   mkd_state_type           state_ff, state_in;
   logic                    events_enabled_ff;
   logic [CSR_W-1:0]        debounce_ticks_ff;
   logic [TIME_WIDTH-1:0]   now_ticks_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [LINE_W-1:0]       line_ff, line_in;
   logic [OUTCOME_W-1:0]    mode_ff, mode_in;
   logic [2:0]              ev_cnt_ff, ev_cnt_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_is_status_ff, rsp_is_status_in;
   logic [KEY_W-1:0]        rsp_key_ff, rsp_key_in;
   logic                    rsp_pressed_ff, rsp_pressed_in;
   logic [DUR_W-1:0]        rsp_duration_ff, rsp_duration_in;
   logic [OUTCOME_W-1:0]    rsp_outcome_ff, rsp_outcome_in;
   logic                    rsp_last_ff, rsp_last_in;

   // datapath
   logic                    req_fire;
   logic                    col_unknown;
   logic                    found_any;
   logic [LINE_W-1:0]       found_line;
   logic [KEY_AW-1:0]       key_addr;
   logic [KEY_XW-1:0]       key_ext;
   logic                    st_rd_en;
   logic                    st_wr_en;
   logic                    st_rd_down;
   logic [TIME_WIDTH-1:0]   st_rd_time;
   logic [TIME_WIDTH-1:0]   elapsed;
   logic [TIME_XW-1:0]      elapsed_ext;
   logic [TIME_XW-1:0]      now_ext;
   logic                    is_press;
   logic                    press_ok;
   logic                    change;
   logic                    emit;
   logic                    out_free;
   logic                    eval_go;
   logic                    last_line;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // column decode and lowest low line
   assign col_unknown = !req_column_known || (int'(req_column) >= COLUMNS);

   always_comb begin
      found_any  = 1'b0;
      found_line = '0;
      for (int i = 0; i < HITS_W; i++) begin
         if (i < LINES && req_column_high && req_line_hits[i] && !found_any) begin
            found_any  = 1'b1;
            found_line = LINE_W'(i);
         end
      end
   end

   // key index of the current column and line
   assign key_addr = KEY_AW'(col_ff) + KEY_AW'(line_ff) * KEY_AW'(COLUMNS);
   assign key_ext  = KEY_XW'(key_addr);

   // shared elapsed-time unit: now minus the key's last change
   assign elapsed     = now_ticks_ff - st_rd_time;
   assign elapsed_ext = TIME_XW'(elapsed);
   assign now_ext     = TIME_XW'(now_ticks_ff);

   assign is_press  = (mode_ff == OUT_FOUND);
   assign press_ok  = !st_rd_down && (elapsed >= TIME_WIDTH'(debounce_ticks_ff));
   assign change    = is_press ? press_ok : st_rd_down;
   assign emit      = change && events_enabled_ff &&
                      (is_press || (ev_cnt_ff < MAX_RELEASE_EVENTS));
   assign eval_go   = !emit || out_free;
   assign last_line = (line_ff == LINE_W'(LINES - 1));

   // timestamp and flag store
   mkd_key_store #(
      .KEYS       (KEYS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .addr    (key_addr),
      .rd_en   (st_rd_en),
      .wr_en   (st_wr_en),
      .wr_down (is_press),
      .wr_time (now_ticks_ff),
      .rd_down (st_rd_down),
      .rd_time (st_rd_time)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_action == ACT_COLUMN) begin
               state_in = col_unknown ? ST_STATUS : ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (eval_go) begin
               state_in = (is_press || last_line) ? ST_STATUS : ST_FETCH;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      st_rd_en         = 1'b0;
      st_wr_en         = 1'b0;
      col_in           = col_ff;
      line_in          = line_ff;
      mode_in          = mode_ff;
      ev_cnt_in        = ev_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_is_status_in = rsp_is_status_ff;
      rsp_key_in       = rsp_key_ff;
      rsp_pressed_in   = rsp_pressed_ff;
      rsp_duration_in  = rsp_duration_ff;
      rsp_outcome_in   = rsp_outcome_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               col_in    = COL_W'(req_column);
               line_in   = found_any ? found_line : '0;
               ev_cnt_in = '0;
               if (col_unknown) begin
                  mode_in = OUT_UNKNOWN;
               end else if (found_any) begin
                  mode_in = OUT_FOUND;
               end else begin
                  mode_in = OUT_RELEASED;
               end
            end
         end
         ST_FETCH: begin
            st_rd_en = 1'b1;
         end
         ST_EVAL: begin
            if (eval_go) begin
               st_wr_en = change;
               if (!is_press && !last_line) begin
                  line_in = line_ff + 1'b1;
               end
               if (emit) begin
                  rsp_valid_in     = 1'b1;
                  rsp_is_status_in = 1'b0;
                  rsp_key_in       = key_ext[KEY_W-1:0];
                  rsp_pressed_in   = is_press;
                  rsp_duration_in  = is_press ? now_ext[DUR_W-1:0]
                                              : elapsed_ext[DUR_W-1:0];
                  rsp_outcome_in   = OUT_UNKNOWN;
                  rsp_last_in      = 1'b0;
                  if (!is_press) begin
                     ev_cnt_in = ev_cnt_ff + 1'b1;
                  end
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_is_status_in = 1'b1;
               rsp_key_in       = is_press ? key_ext[KEY_W-1:0] : '0;
               rsp_pressed_in   = 1'b0;
               rsp_duration_in  = '0;
               rsp_outcome_in   = mode_ff;
               rsp_last_in      = 1'b1;
            end
         end
         default: begin
            st_rd_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         now_ticks_ff      <= '0;
         events_enabled_ff <= 1'b0;
         debounce_ticks_ff <= DEF_DEBOUNCE_TICKS;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire && req_action == ACT_TICK) begin
            now_ticks_ff <= now_ticks_ff + 1'b1;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_EVENTS_ENABLED: events_enabled_ff <= csr_wdata[0];
               CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata;
               default:            events_enabled_ff <= events_enabled_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_ff           <= col_in;
      line_ff          <= line_in;
      mode_ff          <= mode_in;
      ev_cnt_ff        <= ev_cnt_in;
      rsp_is_status_ff <= rsp_is_status_in;
      rsp_key_ff       <= rsp_key_in;
      rsp_pressed_ff   <= rsp_pressed_in;
      rsp_duration_ff  <= rsp_duration_in;
      rsp_outcome_ff   <= rsp_outcome_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_status   = rsp_is_status_ff;
   assign rsp_key         = rsp_key_ff;
   assign rsp_key_pressed = rsp_pressed_ff;
   assign rsp_duration    = rsp_duration_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_last        = rsp_last_ff;

   // a store read is always followed by its evaluation
   a_fetch_then_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |=> state_ff == ST_EVAL)
      else $error("fetch not followed by evaluation");

   // store writes only while evaluating a fetched key
   a_write_in_eval: assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> state_ff == ST_EVAL)
      else $error("store write outside evaluation");

   // only a status result closes a transaction
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_is_status_ff == rsp_last_ff)
      else $error("last flag does not match status");

   // release events per transaction stay bounded
   a_event_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> ev_cnt_ff <= MAX_RELEASE_EVENTS)
      else $error("too many release events");

endmodule

### rtl/core/mkd_key_store.sv
// ----------------------------------------------------------------------------
// mkd_key_store
// Per-key pressed flags and last-change timestamps. Timestamps live in a
// memory with a registered read; valid bits make never-written entries read
// as zero after reset.
// ----------------------------------------------------------------------------
module mkd_key_store
   import mkd_pkg::*;
#(
   parameter int KEYS       = DEF_KEYS,
   parameter int TIME_WIDTH = DEF_TIME_WIDTH,
   localparam int ADDR_W    = (KEYS > 1) ? $clog2(KEYS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ADDR_W-1:0]     addr,
   input  logic                  rd_en,
   input  logic                  wr_en,
   input  logic                  wr_down,
   input  logic [TIME_WIDTH-1:0] wr_time,
   output logic                  rd_down,
   output logic [TIME_WIDTH-1:0] rd_time
);

   logic [TIME_WIDTH-1:0] time_mem_ff [KEYS];
   logic [TIME_WIDTH-1:0] time_q_ff;
   logic [KEYS-1:0]       valid_ff;
   logic [KEYS-1:0]       down_ff;
   logic                  rd_valid_ff;
   logic                  rd_down_ff;

   // timestamp memory, one port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem_ff[addr] <= wr_time;
      end
      if (rd_en) begin
         time_q_ff <= time_mem_ff[addr];
      end
   end

   // valid bits and pressed flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         down_ff     <= '0;
         rd_valid_ff <= 1'b0;
         rd_down_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
            down_ff[addr]  <= wr_down;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[addr];
            rd_down_ff  <= down_ff[addr];
         end
      end
   end

   assign rd_down = rd_down_ff;
   assign rd_time = rd_valid_ff ? time_q_ff : '0;

endmodule
